// ===== sv/tpvd_pkg.sv =====
package tpvd_pkg;

	// Fixed field widths
	localparam int OP_BITS       = 2;
	localparam int DUR_BITS      = 16;
	localparam int SLOT_BITS     = 4;
	localparam int US_BITS       = 26;
	localparam int GRANT_BITS    = 17;
	localparam int CFG_IDX_BITS  = 2;

	localparam int MS_TO_US = 1000;
	localparam logic [GRANT_BITS-1:0] GRANT_MAX = '1;

	// floor(x / 1000) == (x * RECIP_M) >> RECIP_SHIFT for every x below 2**32
	localparam int RECIP_BITS  = 29;
	localparam int RECIP_SHIFT = 38;
	localparam logic [RECIP_BITS-1:0] RECIP_M = 29'd274877907;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE_LEVEL      = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIRECTION_LEVEL   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIRECTION_PRESENT = 2'd2;

	typedef enum logic [OP_BITS-1:0] {
		OP_TICK = 2'd0,
		OP_ON   = 2'd1,
		OP_OFF  = 2'd2,
		OP_LOAD = 2'd3
	} tpvd_op_t;

	typedef struct packed {
		logic en_level;
		logic dir_level;
		logic dir_present;
	} tpvd_cfg_t;

	typedef struct packed {
		logic setup;
		logic stop;
		logic tick;
	} tpvd_chan_cmd_t;

	typedef struct packed {
		logic latch;
		logic clear_res;
		logic tick;
		logic stop;
		logic scan_init;
		logic scan_step;
		logic pick;
		logic fetch;
		logic setup;
		logic grant;
		logic emit;
	} tpvd_cmd_t;

	typedef struct packed {
		tpvd_op_t op;
		logic     scan_last;
		logic     found;
	} tpvd_stat_t;

	typedef struct packed {
		logic                  enable_pin;
		logic                  direction_pin;
		logic                  profile_found;
		logic [SLOT_BITS-1:0]  selected_profile;
		logic [GRANT_BITS-1:0] granted_ms;
	} tpvd_result_t;

endpackage

// ===== sv/tpvd_chan.sv =====
module tpvd_chan
	import tpvd_pkg::*;
#(
	parameter int TIME_BITS = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tpvd_chan_cmd_t       cmd,
	input  logic                 hold_active,
	input  logic [TIME_BITS-1:0] on_time,
	input  logic [TIME_BITS-1:0] off_time,
	output logic                 stage_on
);

	logic [TIME_BITS-1:0] on_q, off_q, cd_q, cd_dec;
	logic                 run_q, stage_q;

	assign cd_dec   = (cd_q != '0) ? cd_q - 1'b1 : '0;
	assign stage_on = stage_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q    <= '0;
			off_q   <= '0;
			cd_q    <= '0;
			run_q   <= 1'b0;
			stage_q <= 1'b0;
		end else if (cmd.setup) begin
			on_q  <= on_time;
			off_q <= off_time;
			if (on_time != '0) begin
				stage_q <= 1'b1;
				run_q   <= 1'b1;
				cd_q    <= on_time;
			end else begin
				stage_q <= 1'b0;
				run_q   <= 1'b0;
				cd_q    <= '0;
			end
		end else if (cmd.stop) begin
			stage_q <= 1'b0;
			run_q   <= 1'b0;
			cd_q    <= '0;
		end else if (cmd.tick && run_q) begin
			if (cd_dec != '0) begin
				cd_q <= cd_dec;
			end else if (stage_q) begin
				if (off_q != '0) begin
					stage_q <= 1'b0;
					cd_q    <= off_q;
				end else begin
					// no off phase: enable drops, direction holds its active level
					run_q <= 1'b0;
					cd_q  <= '0;
					if (!hold_active) stage_q <= 1'b0;
				end
			end else if (on_q != '0) begin
				stage_q <= 1'b1;
				cd_q    <= on_q;
			end else begin
				run_q <= 1'b0;
				cd_q  <= '0;
			end
		end
	end

	a_run_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (cd_q != '0))
		else $error("channel timer pending with zero countdown");

endmodule

// ===== sv/tpvd_dp.sv =====
module tpvd_dp
	import tpvd_pkg::*;
#(
	parameter int PROFILE_ENTRIES = 9,
	parameter int TIME_BITS       = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tpvd_cmd_t            cmd,
	input  tpvd_cfg_t            cfg,
	input  logic [OP_BITS-1:0]   opcode,
	input  logic [DUR_BITS-1:0]  duration_ms,
	input  logic [SLOT_BITS-1:0] profile_slot,
	input  logic [TIME_BITS-1:0] profile_time_us,
	input  logic [TIME_BITS-1:0] profile_period_us,
	input  logic [TIME_BITS-1:0] profile_duty_enable_us,
	input  logic [TIME_BITS-1:0] profile_duty_direction_us,
	output tpvd_stat_t           stat,
	output tpvd_result_t         res
);

	localparam int IW = (PROFILE_ENTRIES > 1) ? $clog2(PROFILE_ENTRIES) : 1;
	localparam int CW = (TIME_BITS > US_BITS) ? TIME_BITS : US_BITS;
	localparam int PW = CW + RECIP_BITS;
	localparam int QW = PW - RECIP_SHIFT;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
	localparam logic [IW-1:0]        LAST_IDX = IW'(PROFILE_ENTRIES - 1);

	// Profile table
	logic [TIME_BITS-1:0] tbl_time_q   [PROFILE_ENTRIES];
	logic [TIME_BITS-1:0] tbl_period_q [PROFILE_ENTRIES];
	logic [TIME_BITS-1:0] tbl_duty_e_q [PROFILE_ENTRIES];
	logic [TIME_BITS-1:0] tbl_duty_d_q [PROFILE_ENTRIES];

	tpvd_op_t             op_q;
	logic [US_BITS-1:0]   us_q, us_calc;
	logic                 slot_ok, load_wr;

	logic [IW-1:0]        scan_idx_q, rd_idx, lo_i_q, ge_i_q, sel_q;
	logic                 lo_v_q, ge_v_q, found_q;
	logic [TIME_BITS-1:0] lo_t_q, ge_t_q, rd_time;
	logic                 t_nz, t_below, take_lo, take_ge;

	logic [TIME_BITS-1:0]  period_q, duty_e_q, duty_d_q;
	logic [CW-1:0]         total_q, total_calc;
	logic [PW-1:0]         prod_q;
	logic [QW-1:0]         quot;
	logic [GRANT_BITS-1:0] granted_q;

	logic [TIME_BITS-1:0] total_sat, on_e, off_e, on_d, off_d;
	logic                 eq_e, eq_d, en_stage, dir_stage;
	tpvd_chan_cmd_t       en_cmd, dir_cmd;

	assign us_calc = US_BITS'(duration_ms) * US_BITS'(MS_TO_US);
	assign slot_ok = ({1'b0, profile_slot} < (SLOT_BITS + 1)'(PROFILE_ENTRIES));
	assign load_wr = cmd.latch && (tpvd_op_t'(opcode) == OP_LOAD) && slot_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PROFILE_ENTRIES; i++) begin
				tbl_time_q[i]   <= '0;
				tbl_period_q[i] <= '0;
				tbl_duty_e_q[i] <= '0;
				tbl_duty_d_q[i] <= '0;
			end
		end else if (load_wr) begin
			tbl_time_q[profile_slot[IW-1:0]]   <= profile_time_us;
			tbl_period_q[profile_slot[IW-1:0]] <= profile_period_us;
			tbl_duty_e_q[profile_slot[IW-1:0]] <= profile_duty_enable_us;
			tbl_duty_d_q[profile_slot[IW-1:0]] <= profile_duty_direction_us;
		end
	end

	// One read address: scan index while scanning, chosen entry otherwise
	assign rd_idx  = cmd.scan_step ? scan_idx_q : sel_q;
	assign rd_time = tbl_time_q[rd_idx];
	assign t_nz    = (rd_time != '0);
	assign t_below = (CW'(rd_time) < CW'(us_q));
	assign take_lo = t_nz && t_below && (!lo_v_q || (lo_t_q < rd_time));
	assign take_ge = t_nz && !t_below && (!ge_v_q || (ge_t_q >= rd_time));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= OP_TICK;
			scan_idx_q <= '0;
			lo_v_q     <= 1'b0;
			ge_v_q     <= 1'b0;
			found_q    <= 1'b0;
			sel_q      <= '0;
			granted_q  <= '0;
		end else begin
			if (cmd.latch) op_q <= tpvd_op_t'(opcode);
			if (cmd.clear_res) begin
				found_q   <= 1'b0;
				sel_q     <= '0;
				granted_q <= '0;
			end
			if (cmd.scan_init) begin
				scan_idx_q <= '0;
				lo_v_q     <= 1'b0;
				ge_v_q     <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (take_lo) lo_v_q <= 1'b1;
				if (take_ge) ge_v_q <= 1'b1;
				if (!stat.scan_last) scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (cmd.pick) begin
				found_q <= 1'b1;
				sel_q   <= ge_v_q ? ge_i_q : lo_i_q;
			end
			if (cmd.grant) granted_q <= (quot > QW'(GRANT_MAX)) ? GRANT_MAX
			                                                   : quot[GRANT_BITS-1:0];
		end
	end

	assign total_calc = (CW'(us_q) < CW'(tbl_period_q[rd_idx])) ? CW'(tbl_period_q[rd_idx])
	                                                            : CW'(us_q);
	assign quot = prod_q[PW-1:RECIP_SHIFT];

	always_ff @(posedge clk) begin
		if (cmd.latch) us_q <= us_calc;
		if (cmd.scan_step && take_lo) begin
			lo_t_q <= rd_time;
			lo_i_q <= scan_idx_q;
		end
		if (cmd.scan_step && take_ge) begin
			ge_t_q <= rd_time;
			ge_i_q <= scan_idx_q;
		end
		if (cmd.fetch) begin
			period_q <= tbl_period_q[rd_idx];
			duty_e_q <= tbl_duty_e_q[rd_idx];
			duty_d_q <= tbl_duty_d_q[rd_idx];
			total_q  <= total_calc;
		end
		if (cmd.setup) prod_q <= PW'(total_q) * PW'(RECIP_M);
	end

	// Duty equal to period stretches both to the granted total; off-time floors at zero
	assign total_sat = (total_q > CW'(TIME_MAX)) ? TIME_MAX : total_q[TIME_BITS-1:0];
	assign eq_e  = (duty_e_q == period_q);
	assign eq_d  = (duty_d_q == period_q);
	assign on_e  = eq_e ? total_sat : duty_e_q;
	assign on_d  = eq_d ? total_sat : duty_d_q;
	assign off_e = (!eq_e && (period_q > duty_e_q)) ? period_q - duty_e_q : '0;
	assign off_d = (!eq_d && (period_q > duty_d_q)) ? period_q - duty_d_q : '0;

	assign en_cmd  = '{setup: cmd.setup, stop: cmd.stop, tick: cmd.tick};
	assign dir_cmd = '{setup: cmd.setup && cfg.dir_present,
	                   stop:  cmd.stop && cfg.dir_present,
	                   tick:  cmd.tick && cfg.dir_present};

	tpvd_chan #(.TIME_BITS(TIME_BITS)) u_en_chan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (en_cmd),
		.hold_active (1'b0),
		.on_time     (on_e),
		.off_time    (off_e),
		.stage_on    (en_stage)
	);

	tpvd_chan #(.TIME_BITS(TIME_BITS)) u_dir_chan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dir_cmd),
		.hold_active (1'b1),
		.on_time     (on_d),
		.off_time    (off_d),
		.stage_on    (dir_stage)
	);

	assign stat.op        = op_q;
	assign stat.scan_last = !t_nz || (scan_idx_q == LAST_IDX);
	assign stat.found     = lo_v_q || ge_v_q;

	assign res.enable_pin       = en_stage ? cfg.en_level : ~cfg.en_level;
	assign res.direction_pin    = cfg.dir_present && (dir_stage ? cfg.dir_level
	                                                           : ~cfg.dir_level);
	assign res.profile_found    = found_q;
	assign res.selected_profile = SLOT_BITS'(sel_q);
	assign res.granted_ms       = granted_q;

	a_grant_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(granted_q != '0) |-> found_q)
		else $error("granted length without a chosen entry");

	a_sel_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> ({1'b0, sel_q} < (IW + 1)'(PROFILE_ENTRIES)))
		else $error("chosen entry outside the table");

endmodule

// ===== sv/tpvd_ctrl.sv =====
module tpvd_ctrl
	import tpvd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_free,
	input  tpvd_stat_t stat,
	output logic       in_stall,
	output tpvd_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_DISPATCH = 8'b0000_0010,
		S_SCAN     = 8'b0000_0100,
		S_PICK     = 8'b0000_1000,
		S_FETCH    = 8'b0001_0000,
		S_SETUP    = 8'b0010_0000,
		S_GRANT    = 8'b0100_0000,
		S_EMIT     = 8'b1000_0000
	} tpvd_state_t;

	tpvd_state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.clear_res = 1'b1;
				unique case (stat.op)
					OP_TICK: begin
						cmd.tick = 1'b1;
						state_d  = S_EMIT;
					end
					OP_ON: begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
					OP_OFF: begin
						cmd.stop = 1'b1;
						state_d  = S_EMIT;
					end
					OP_LOAD: state_d = S_EMIT;
					default: state_d = S_EMIT;
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = S_PICK;
			end
			S_PICK: begin
				if (stat.found) begin
					cmd.pick = 1'b1;
					state_d  = S_FETCH;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_SETUP;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_GRANT;
			end
			S_GRANT: begin
				cmd.grant = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ===== sv/timed_pwm_vibrator_driver.sv =====
// Vibrator pin driver with a profile table. Each accepted input beat is one command:
// a one-microsecond tick, power on, power off or a profile load, and each gives exactly
// one result beat with the current pin levels and, for a power on that found an
// entry, the chosen slot and the granted length in milliseconds. A power on scans the
// table entries up to the first zero time, at most PROFILE_ENTRIES of them, through
// one read port, one entry per clock, then picks, fetches, sets up the channels and
// grants; a power on that finds nothing skips those last steps. The result sits in an
// output register, so the next beat is taken while it waits to be drained. The table
// lives in flops cleared by reset, with no clearing pass. Write the configuration
// registers only while no command is in flight.
module timed_pwm_vibrator_driver
	import tpvd_pkg::*;
#(
	parameter int PROFILE_ENTRIES = 9,
	parameter int TIME_BITS       = 26
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// command channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [OP_BITS-1:0]      opcode,
	input  logic [DUR_BITS-1:0]     duration_ms,
	input  logic [SLOT_BITS-1:0]    profile_slot,
	input  logic [TIME_BITS-1:0]    profile_time_us,
	input  logic [TIME_BITS-1:0]    profile_period_us,
	input  logic [TIME_BITS-1:0]    profile_duty_enable_us,
	input  logic [TIME_BITS-1:0]    profile_duty_direction_us,
	// result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    enable_pin,
	output logic                    direction_pin,
	output logic                    profile_found,
	output logic [SLOT_BITS-1:0]    selected_profile,
	output logic [GRANT_BITS-1:0]   granted_ms,
	// configuration write port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic                    cfg_data
);

	tpvd_cfg_t    cfg_q;
	tpvd_cmd_t    cmd;
	tpvd_stat_t   stat;
	tpvd_result_t res, res_q;
	logic         out_valid_q, out_free;

	// Configuration registers; writes to unused indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.en_level    <= 1'b1;
			cfg_q.dir_level   <= 1'b1;
			cfg_q.dir_present <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE_LEVEL:      cfg_q.en_level    <= cfg_data;
				CFG_DIRECTION_LEVEL:   cfg_q.dir_level   <= cfg_data;
				CFG_DIRECTION_PRESENT: cfg_q.dir_present <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: accepts a beat in idle, walks the datapath through the command
	tpvd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Table, profile search, channel setup arithmetic and the two pin timers
	tpvd_dp #(
		.PROFILE_ENTRIES (PROFILE_ENTRIES),
		.TIME_BITS       (TIME_BITS)
	) u_dp (
		.clk                       (clk),
		.arst_n                    (arst_n),
		.cmd                       (cmd),
		.cfg                       (cfg_q),
		.opcode                    (opcode),
		.duration_ms               (duration_ms),
		.profile_slot              (profile_slot),
		.profile_time_us           (profile_time_us),
		.profile_period_us         (profile_period_us),
		.profile_duty_enable_us    (profile_duty_enable_us),
		.profile_duty_direction_us (profile_duty_direction_us),
		.stat                      (stat),
		.res                       (res)
	);

	// Output register: free when empty or draining this clock
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        out_valid_q <= 1'b0;
		else if (cmd.emit)  out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	// Hold the result beat until it is taken
	always_ff @(posedge clk) begin
		if (cmd.emit) res_q <= res;
	end

	assign out_valid        = out_valid_q;
	assign enable_pin       = res_q.enable_pin;
	assign direction_pin    = res_q.direction_pin;
	assign profile_found    = res_q.profile_found;
	assign selected_profile = res_q.selected_profile;
	assign granted_ms       = res_q.granted_ms;

	a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("result written over a beat still waiting");

endmodule

// ===== test/tb_timed_pwm_vibrator_driver.sv =====
module tb_timed_pwm_vibrator_driver;
	import tpvd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PROFILE_ENTRIES = 9;
	localparam int HALF_PERIOD     = 4;
	localparam int RESET_CYCLES    = 7;
	// Leave margin after the last result
	localparam int SETTLE_CYCLES   = 40;
	// Watchdog limit on the whole run, well above the slowest legal run
	localparam int CYCLE_LIMIT     = 400000;
	localparam int EN_CH           = 0;
	localparam int DIR_CH          = 1;

	// One command beat as the sender offers it
	typedef struct packed {
		tpvd_op_t              op;
		logic [DUR_BITS-1:0]   dur;
		logic [SLOT_BITS-1:0]  slot;
		logic [US_BITS-1:0]    t_us;
		logic [US_BITS-1:0]    per_us;
		logic [US_BITS-1:0]    duty_en_us;
		logic [US_BITS-1:0]    duty_dir_us;
	} vib_cmd_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    in_valid     = 1'b0;
	logic                    in_stall;
	vib_cmd_t                cmd_beat     = '0;
	logic                    out_valid;
	logic                    out_stall    = 1'b0;
	logic                    enable_pin;
	logic                    direction_pin;
	logic                    profile_found;
	logic [SLOT_BITS-1:0]    selected_profile;
	logic [GRANT_BITS-1:0]   granted_ms;
	logic                    cfg_we       = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
	logic                    cfg_data     = 1'b0;

	// Commands waiting to be offered, and pin reports owed by the block
	vib_cmd_t     cmd_backlog[$];
	tpvd_result_t pin_reports_due[$];

	// Shadow of the block: profile table, both PWM channels, configuration
	logic [US_BITS-1:0] prof_time     [PROFILE_ENTRIES];
	logic [US_BITS-1:0] prof_per      [PROFILE_ENTRIES];
	logic [US_BITS-1:0] prof_duty_en  [PROFILE_ENTRIES];
	logic [US_BITS-1:0] prof_duty_dir [PROFILE_ENTRIES];
	logic [US_BITS-1:0] ch_on    [2];
	logic [US_BITS-1:0] ch_off   [2];
	logic [US_BITS-1:0] ch_cd    [2];
	logic               ch_run   [2];
	logic               ch_stage [2];
	logic               lvl_en     = 1'b1;
	logic               lvl_dir    = 1'b1;
	logic               dir_fitted = 1'b0;

	// Traffic shaping, set by the sequence between phases
	int  send_idle_pct = 0;
	int  stall_pct     = 0;
	int  hold_req      = 0;
	int  phase_id      = 0;
	int  rx_phase_seen = 0;
	int  rx_hold       = 0;
	bit  took_beat     = 1'b0;
	int  cycle_count   = 0;
	int  err_count     = 0;
	int  cmds_taken    = 0;
	int  on_found      = 0;
	int  on_missed     = 0;

	timed_pwm_vibrator_driver #(
		.PROFILE_ENTRIES(PROFILE_ENTRIES),
		.TIME_BITS(US_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(cmd_beat.op),
		.duration_ms(cmd_beat.dur),
		.profile_slot(cmd_beat.slot),
		.profile_time_us(cmd_beat.t_us),
		.profile_period_us(cmd_beat.per_us),
		.profile_duty_enable_us(cmd_beat.duty_en_us),
		.profile_duty_direction_us(cmd_beat.duty_dir_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.enable_pin(enable_pin),
		.direction_pin(direction_pin),
		.profile_found(profile_found),
		.selected_profile(selected_profile),
		.granted_ms(granted_ms),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Clamp a wide microsecond value to the table width
	function automatic logic [US_BITS-1:0] clamp_us(input logic [63:0] v);
		if ((v >> US_BITS) != 0)
			return '1;
		return US_BITS'(v);
	endfunction

	// Drop a channel: cancel its timer and go inactive
	task automatic halt_channel(input int ch);
		ch_run[ch]   = 1'b0;
		ch_cd[ch]    = '0;
		ch_stage[ch] = 1'b0;
	endtask

	// Load on/off times for a channel; a duty equal to the period stretches to the total
	task automatic arm_channel(input int ch, input logic [63:0] total,
			input logic [63:0] period, input logic [63:0] duty);
		halt_channel(ch);
		if (duty == period) begin
			period = total;
			duty   = total;
		end
		ch_on[ch]  = clamp_us(duty);
		ch_off[ch] = (period > duty) ? clamp_us(period - duty) : '0;
	endtask

	// Advance one channel by one microsecond
	task automatic tick_channel(input int ch);
		if (!ch_run[ch])
			return;
		if (ch_cd[ch] != '0)
			ch_cd[ch] = ch_cd[ch] - 1'b1;
		if (ch_cd[ch] != '0)
			return;
		ch_run[ch] = 1'b0;
		if (ch_stage[ch]) begin
			// enable always drops at the end of its on-time; direction only with an off-time
			if (ch == EN_CH)
				ch_stage[ch] = 1'b0;
			if (ch_off[ch] != '0) begin
				ch_stage[ch] = 1'b0;
				ch_run[ch]   = 1'b1;
				ch_cd[ch]    = ch_off[ch];
			end
		end else if (ch_on[ch] != '0) begin
			ch_stage[ch] = 1'b1;
			ch_run[ch]   = 1'b1;
			ch_cd[ch]    = ch_on[ch];
		end
	endtask

	// Apply one command to the shadow state and form the pin report it yields
	task automatic vibrate_step(input vib_cmd_t c, output tpvd_result_t r);
		logic [63:0] us;
		logic [63:0] per;
		logic [63:0] total;
		logic [63:0] grant;
		int lo;
		int ge;
		r = '0;
		case (c.op)
			OP_TICK: begin
				tick_channel(EN_CH);
				if (dir_fitted)
					tick_channel(DIR_CH);
			end
			OP_ON: begin
				us = 64'(c.dur) * MS_TO_US;
				lo = -1;
				ge = -1;
				// Scan up to the first empty key: nearest key at or above the request
				// (later wins a tie), else nearest below (earlier wins a tie)
				for (int i = 0; i < PROFILE_ENTRIES; i++) begin
					if (prof_time[i] == '0)
						break;
					if (64'(prof_time[i]) < us) begin
						if (lo < 0 || prof_time[lo] < prof_time[i])
							lo = i;
					end else if (ge < 0 || prof_time[ge] >= prof_time[i]) begin
						ge = i;
					end
				end
				if (ge < 0)
					ge = lo;
				if (ge >= 0) begin
					per   = 64'(prof_per[ge]);
					total = (us < per) ? per : us;
					if (dir_fitted)
						arm_channel(DIR_CH, total, per, 64'(prof_duty_dir[ge]));
					arm_channel(EN_CH, total, per, 64'(prof_duty_en[ge]));
					// Start every configured channel with a nonzero on-time in the active stage
					for (int ch = 0; ch < 2; ch++) begin
						if ((ch == EN_CH || dir_fitted) && ch_on[ch] != '0) begin
							ch_stage[ch] = 1'b1;
							ch_run[ch]   = 1'b1;
							ch_cd[ch]    = ch_on[ch];
						end
					end
					grant = total / MS_TO_US;
					if (grant > 64'(GRANT_MAX))
						grant = 64'(GRANT_MAX);
					r.profile_found    = 1'b1;
					r.selected_profile = SLOT_BITS'(ge);
					r.granted_ms       = GRANT_BITS'(grant);
				end
			end
			OP_OFF: begin
				halt_channel(EN_CH);
				if (dir_fitted)
					halt_channel(DIR_CH);
			end
			OP_LOAD: begin
				// slots past the table are dropped silently
				if (c.slot < PROFILE_ENTRIES) begin
					prof_time[c.slot]     = c.t_us;
					prof_per[c.slot]      = c.per_us;
					prof_duty_en[c.slot]  = c.duty_en_us;
					prof_duty_dir[c.slot] = c.duty_dir_us;
				end
			end
		endcase
		r.enable_pin    = ch_stage[EN_CH] ? lvl_en : ~lvl_en;
		r.direction_pin = dir_fitted ? (ch_stage[DIR_CH] ? lvl_dir : ~lvl_dir) : 1'b0;
	endtask

	function automatic vib_cmd_t mk(input tpvd_op_t op, input int dur, input int slot,
			input logic [US_BITS-1:0] t, input logic [US_BITS-1:0] p,
			input logic [US_BITS-1:0] de, input logic [US_BITS-1:0] dd);
		vib_cmd_t c;
		c.op          = op;
		c.dur         = DUR_BITS'(dur);
		c.slot        = SLOT_BITS'(slot);
		c.t_us        = t;
		c.per_us      = p;
		c.duty_en_us  = de;
		c.duty_dir_us = dd;
		return c;
	endfunction

	// Mostly small times so PWM periods actually turn over under ticks, with
	// occasional full-width values and empty keys to cut the scan short
	function automatic vib_cmd_t random_cmd();
		vib_cmd_t c;
		int roll;
		c.dur  = ($urandom_range(0, 99) < 85) ? DUR_BITS'($urandom_range(0, 12))
			: DUR_BITS'($urandom_range(0, 60000));
		c.slot = ($urandom_range(0, 99) < 94) ? SLOT_BITS'($urandom_range(0, 8))
			: SLOT_BITS'($urandom_range(9, 15));
		roll = $urandom_range(0, 99);
		if (roll < 80)
			c.t_us = US_BITS'($urandom_range(1, 24) * 500);
		else if (roll < 88)
			c.t_us = '0;
		else
			c.t_us = US_BITS'($urandom);
		c.per_us = ($urandom_range(0, 99) < 85) ? US_BITS'($urandom_range(0, 12))
			: US_BITS'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 75)
			c.duty_en_us = US_BITS'($urandom_range(0, 14));
		else if (roll < 88)
			c.duty_en_us = c.per_us;
		else
			c.duty_en_us = US_BITS'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 75)
			c.duty_dir_us = US_BITS'($urandom_range(0, 14));
		else if (roll < 88)
			c.duty_dir_us = c.per_us;
		else
			c.duty_dir_us = US_BITS'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 58)
			c.op = OP_TICK;
		else if (roll < 73)
			c.op = OP_ON;
		else if (roll < 80)
			c.op = OP_OFF;
		else
			c.op = OP_LOAD;
		return c;
	endfunction

	// Write one register and mirror it in the shadow configuration
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ENABLE_LEVEL:    lvl_en     = val;
			CFG_DIRECTION_LEVEL: lvl_dir    = val;
			default:             dir_fitted = val;
		endcase
	endtask

	// Hold until every command is taken and every report is back, then settle
	task automatic wait_drained();
		@(posedge clk);
		while (cmd_backlog.size() != 0 || in_valid || pin_reports_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reconfigure while idle, set the traffic shape, then queue random commands
	task automatic run_phase(input logic en_lvl, input logic dir_lvl, input logic dir_on,
			input int idle_in, input int stall_out, input int hold, input int n);
		wait_drained();
		write_reg(CFG_ENABLE_LEVEL, en_lvl);
		write_reg(CFG_DIRECTION_LEVEL, dir_lvl);
		write_reg(CFG_DIRECTION_PRESENT, dir_on);
		send_idle_pct = idle_in;
		stall_pct     = stall_out;
		hold_req      = hold;
		phase_id      = phase_id + 1;
		repeat (n) cmd_backlog.push_back(random_cmd());
	endtask

	// Sender: advance to the next command once the current beat is gone; hold the
	// payload steady while stalled, and idle at random between beats
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took_beat)) begin
			if (cmd_backlog.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
				cmd_beat <= cmd_backlog.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a long hold-off at the start of a pressure phase, else random stalls
	always @(negedge clk) begin
		if (phase_id != rx_phase_seen) begin
			rx_phase_seen = phase_id;
			rx_hold       = hold_req;
		end
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold    = rx_hold - 1;
		end else begin
			out_stall <= ($urandom_range(1, 100) <= stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Check each result beat against the oldest owed report, then predict the
	// report for a command beat taken at this edge
	always @(posedge clk) begin
		tpvd_result_t want;
		tpvd_result_t owed;
		if (arst_n && out_valid && !out_stall) begin
			if (pin_reports_due.size() == 0) begin
				$error("result beat with no command outstanding");
				err_count = err_count + 1;
			end else begin
				owed = pin_reports_due.pop_front();
				if (enable_pin !== owed.enable_pin) begin
					$error("enable_pin expected %0d got %0d", owed.enable_pin, enable_pin);
					err_count = err_count + 1;
				end
				if (direction_pin !== owed.direction_pin) begin
					$error("direction_pin expected %0d got %0d",
						owed.direction_pin, direction_pin);
					err_count = err_count + 1;
				end
				if (profile_found !== owed.profile_found) begin
					$error("profile_found expected %0d got %0d",
						owed.profile_found, profile_found);
					err_count = err_count + 1;
				end
				if (selected_profile !== owed.selected_profile) begin
					$error("selected_profile expected %0d got %0d",
						owed.selected_profile, selected_profile);
					err_count = err_count + 1;
				end
				if (granted_ms !== owed.granted_ms) begin
					$error("granted_ms expected %0d got %0d", owed.granted_ms, granted_ms);
					err_count = err_count + 1;
				end
			end
		end
		took_beat = arst_n && in_valid && !in_stall;
		if (took_beat) begin
			vibrate_step(cmd_beat, want);
			pin_reports_due.push_back(want);
			cmds_taken = cmds_taken + 1;
			if (cmd_beat.op == OP_ON) begin
				if (want.profile_found)
					on_found = on_found + 1;
				else
					on_missed = on_missed + 1;
			end
		end
	end

	initial begin
		for (int i = 0; i < PROFILE_ENTRIES; i++) begin
			prof_time[i]     = '0;
			prof_per[i]      = '0;
			prof_duty_en[i]  = '0;
			prof_duty_dir[i] = '0;
		end
		for (int ch = 0; ch < 2; ch++) begin
			ch_on[ch]  = '0;
			ch_off[ch] = '0;
			halt_channel(ch);
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, ties both ways, duty at/above period, a dropped
		// slot, a zero key ending the scan, and full-width values
		write_reg(CFG_ENABLE_LEVEL, 1'b1);
		write_reg(CFG_DIRECTION_LEVEL, 1'b1);
		write_reg(CFG_DIRECTION_PRESENT, 1'b1);
		cmd_backlog.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(mk(OP_ON, 60000, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(mk(OP_OFF, 0, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(mk(OP_LOAD, 0, 0, 3000, 4, 2, 1));
		cmd_backlog.push_back(mk(OP_LOAD, 0, 1, 1000, 5, 5, 0));
		cmd_backlog.push_back(mk(OP_LOAD, 0, 2, 3000, 3, 7, 3));
		cmd_backlog.push_back(mk(OP_LOAD, 0, 12, 500, 1, 1, 1));
		cmd_backlog.push_back(mk(OP_LOAD, 0, 15, '1, '1, '1, '1));
		cmd_backlog.push_back(mk(OP_ON, 2, 0, 0, 0, 0, 0));
		repeat (6) cmd_backlog.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(mk(OP_ON, 5, 0, 0, 0, 0, 0));
		repeat (4) cmd_backlog.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(mk(OP_ON, 1, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(mk(OP_OFF, 0, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(mk(OP_LOAD, 0, 3, '1, '1, 0, '1));
		cmd_backlog.push_back(mk(OP_ON, 60000, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(mk(OP_ON, 0, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0));

		// Random phases: levels and direction presence change only while drained
		run_phase(1'b1, 1'b1, 1'b1, 0, 0, 0, 300);
		run_phase(1'b0, 1'b0, 1'b1, 81, 0, 0, 300);
		run_phase(1'b1, 1'b0, 1'b0, 0, 81, 0, 300);
		run_phase(1'b0, 1'b1, 1'b1, 11, 11, 0, 300);
		// Pressure: receiver holds off long enough for the block to back up its input
		run_phase(1'b1, 1'b1, 1'b1, 0, 0, 400, 200);
		run_phase(1'b0, 1'b0, 1'b0, 30, 30, 0, 300);

		wait_drained();
		$display("Covered %0d command beats over %0d configuration phases",
			cmds_taken, phase_id + 1);
		$display("Power-ons: %0d picked a profile, %0d found none", on_found, on_missed);
		if (err_count == 0 && pin_reports_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
